>>> rtl/fixed_block_pool_allocator_top_defines.svh
// Assertion macros shared by the fixed block pool allocator RTL.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FBPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbpa assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbpa assertion failed");

`endif

>>> rtl/fbpa_pkg.sv
// Types, constants and helper functions of the fixed block pool allocator.
package fbpa_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int WORD_BYTES  = 8;
  localparam int REQUEST_CAP = 4096;

  localparam int IDX_W    = $clog2(MAX_BLOCKS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int POOL_W   = 20;
  localparam int REQ_W    = 13;
  localparam int STRIDE_W = 13;
  localparam int CFG_A_W  = 1;

  localparam logic [REQ_W-1:0]    REQ_RESET    = REQ_W'(8);
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(2 * WORD_BYTES);

  localparam logic [CFG_A_W-1:0] CFG_POOL_BYTES = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_REQ_BYTES  = 1'b1;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_TOO_SMALL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_LINK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  granted_index;
    logic [POOL_W-1:0] granted_offset;
    logic [CNT_W-1:0]  free_blocks;
  } out_item_t;

  // One word of the block memory: allocation mark and free-list link.
  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] link;
  } blk_entry_t;

  // Header word plus the request rounded up to whole words, at least two words.
  function automatic logic [STRIDE_W-1:0] stride_for(input logic [REQ_W-1:0] req);
    logic [REQ_W-1:0] r;
    logic [REQ_W-1:0] up;
    r  = (req > REQ_W'(REQUEST_CAP)) ? REQ_W'(REQUEST_CAP) : req;
    up = (r + REQ_W'(WORD_BYTES - 1)) & ~REQ_W'(WORD_BYTES - 1);
    if (r <= REQ_W'(WORD_BYTES)) begin
      return STRIDE_W'(2 * WORD_BYTES);
    end
    return STRIDE_W'(WORD_BYTES) + STRIDE_W'(up);
  endfunction

endpackage

>>> rtl/fbpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/fbpa_div.sv
// Restoring divider that produces one quotient bit per cycle.
module fbpa_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 13,
  localparam int STEP_W = $clog2(NUM_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    shifted;
  logic              fits;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, den_r});
  assign done    = busy_r && (step_r == '0);
  assign quo     = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_W);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (step_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r - STEP_W'(1);
        rem_nxt  = fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
        quo_nxt  = {quo_r[NUM_W-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
  end

endmodule

>>> rtl/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator: free list and allocation marks live in one
// 1024 x 11 block memory (mark plus link). Allocate, free and the unused command
// read the memory in the accept cycle; in EXEC, once the output register is free,
// they load the result register and a successful allocate or free writes back.
// A new command is taken only in IDLE. Init checks the pool size, the divider derives
// the block count, then the link walk writes one entry per cycle. No clearing pass is
// needed after reset, since no entry's contents are used before an init has written it.
`include "fixed_block_pool_allocator_top_defines.svh"

module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [POOL_W-1:0]   cfg_wdata
);

  localparam int OFF_W = IDX_W + STRIDE_W;

  state_t               state_r, state_nxt;
  logic [1:0]           cmd_r, cmd_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]     blk_cnt_r, blk_cnt_nxt;
  logic [STRIDE_W-1:0]  stride_r, stride_nxt;
  logic [POOL_W-1:0]    pool_r, pool_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [IDX_W-1:0]     walk_r, walk_nxt;
  logic [CNT_W-1:0]     new_cnt_r, new_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic                 accept;
  logic                 out_free;
  logic                 load;
  out_item_t            res;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  blk_entry_t           ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [$bits(blk_entry_t)-1:0] ram_rdata;
  blk_entry_t           rd_entry;
  logic [STRIDE_W-1:0]  stride_calc;
  logic                 too_small;
  logic                 div_start;
  logic                 div_done;
  logic [POOL_W-1:0]    div_quo;
  logic [CNT_W-1:0]     cnt_capped;
  logic                 walk_last;
  logic                 free_bad;
  logic [OFF_W-1:0]     offset_full;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_data    = out_item_r;
  assign rd_entry    = blk_entry_t'(ram_rdata);
  assign stride_calc = stride_for(req_r);
  assign too_small   = (pool_r < (POOL_W'(stride_calc) + POOL_W'(WORD_BYTES)));
  assign cnt_capped  = (div_quo > POOL_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                       : div_quo[CNT_W-1:0];
  assign walk_last   = ({1'b0, walk_r} == (new_cnt_r - CNT_W'(1)));
  assign free_bad    = ({1'b0, idx_r} >= blk_cnt_r) || !rd_entry.used;
  assign offset_full = OFF_W'(2 * WORD_BYTES) + (head_r * stride_r);
  assign ram_raddr   = (in_data.cmd == CMD_ALLOC) ? head_r : in_data.block_index;

  fbpa_ram #(
    .WIDTH ($bits(blk_entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_blk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fbpa_div #(
    .NUM_W (POOL_W),
    .DEN_W (STRIDE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (pool_r - POOL_W'(WORD_BYTES)),
    .den   (stride_calc),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((cmd_r == CMD_INIT) && !too_small) begin
          state_nxt = S_DIV;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        if (walk_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    head_nxt     = head_r;
    free_cnt_nxt = free_cnt_r;
    blk_cnt_nxt  = blk_cnt_r;
    stride_nxt   = stride_r;
    walk_nxt     = walk_r;
    new_cnt_nxt  = new_cnt_r;
    load         = 1'b0;
    div_start    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = idx_r;
    ram_wdata    = '0;
    res          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_data.cmd;
          idx_nxt = in_data.block_index;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_INIT: begin
            if (too_small) begin
              load       = out_free;
              res.status = ST_TOO_SMALL;
            end else begin
              div_start = 1'b1;
            end
          end
          CMD_ALLOC: begin
            load = out_free;
            if (free_cnt_r == '0) begin
              res.status = ST_NO_FREE;
            end else begin
              res.status         = ST_OK;
              res.granted_index  = head_r;
              res.granted_offset = offset_full[POOL_W-1:0];
              ram_we             = out_free;
              ram_waddr          = head_r;
              ram_wdata          = '{used: 1'b1, link: rd_entry.link};
              if (out_free) begin
                head_nxt     = rd_entry.link;
                free_cnt_nxt = free_cnt_r - CNT_W'(1);
              end
            end
          end
          CMD_FREE: begin
            load = out_free;
            if (free_bad) begin
              res.status = ST_BAD_INDEX;
            end else begin
              res.status = ST_OK;
              ram_we     = out_free;
              ram_waddr  = idx_r;
              // The pushed block links to the old head; an empty list ends in zero.
              ram_wdata  = '{used: 1'b0, link: (free_cnt_r == '0) ? '0 : head_r};
              if (out_free) begin
                head_nxt     = idx_r;
                free_cnt_nxt = free_cnt_r + CNT_W'(1);
              end
            end
          end
          default: begin
            load       = out_free;
            res.status = ST_OK;
          end
        endcase
        res.free_blocks = free_cnt_nxt;
      end
      S_DIV: begin
        if (div_done) begin
          new_cnt_nxt = cnt_capped;
          walk_nxt    = '0;
        end
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = walk_r;
        ram_wdata = '{used: 1'b0, link: walk_last ? '0 : walk_r + IDX_W'(1)};
        walk_nxt  = walk_r + IDX_W'(1);
      end
      S_FIN: begin
        load            = out_free;
        res.status      = ST_OK;
        res.free_blocks = new_cnt_r;
        if (out_free) begin
          stride_nxt   = stride_calc;
          blk_cnt_nxt  = new_cnt_r;
          free_cnt_nxt = new_cnt_r;
          head_nxt     = '0;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // Configuration writes and the result register.
  always_comb begin
    pool_nxt = pool_r;
    req_nxt  = req_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_POOL_BYTES: pool_nxt = cfg_wdata;
        CFG_REQ_BYTES:  req_nxt  = cfg_wdata[REQ_W-1:0];
        default:        pool_nxt = pool_r;
      endcase
    end

    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      free_cnt_r  <= '0;
      blk_cnt_r   <= '0;
      stride_r    <= STRIDE_RESET;
      pool_r      <= '0;
      req_r       <= REQ_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      blk_cnt_r   <= blk_cnt_nxt;
      stride_r    <= stride_nxt;
      pool_r      <= pool_nxt;
      req_r       <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    walk_r     <= walk_nxt;
    new_cnt_r  <= new_cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  `FBPA_ASSERT_IMP(a_free_within_pool, clk, rst_n, 1'b1, free_cnt_r <= blk_cnt_r)
  `FBPA_ASSERT_IMP(a_no_write_idle, clk, rst_n, state_r == S_IDLE, !ram_we)
  `FBPA_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, accept, state_r == S_EXEC)
  `FBPA_ASSERT_IMP(a_walk_in_range, clk, rst_n, state_r == S_LINK, CNT_W'(walk_r) < new_cnt_r)
  `FBPA_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_done, state_r == S_DIV)

endmodule

>>> dv/fixed_block_pool_allocator_top_test.sv
// Self-checking testbench for the block pool allocator: directed and random commands.
module fixed_block_pool_allocator_top_test;
  import fbpa_pkg::*;

  // The fourth command code has no operation behind it.
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int POOL_MAX = (1 << POOL_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [POOL_W-1:0] cfg_wdata = '0;

  fixed_block_pool_allocator_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Shadow of the pool: settings, free list, marks and counters.
  int unsigned pool_cfg = 0;
  int unsigned req_cfg = 8;
  logic [IDX_W-1:0] link_mem [MAX_BLOCKS];
  bit used_mark [MAX_BLOCKS];
  logic [IDX_W-1:0] head = '0;
  bit list_empty = 1'b1;
  int unsigned free_cnt = 0;
  int unsigned blk_count = 0;
  int unsigned stride = 2 * WORD_BYTES;
  logic [IDX_W-1:0] held_blocks [$];

  in_item_t cmd_queue [$];
  out_item_t pool_replies [$];
  int unsigned items_sent = 0;
  int unsigned items_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 80;
  int unsigned grants = 0;
  int unsigned returns = 0;
  int unsigned refusals = 0;
  int unsigned pool_builds = 0;
  int unsigned pool_settings = 0;

  function automatic int unsigned block_stride_of(input int unsigned req);
    int unsigned r;
    r = (req > REQUEST_CAP) ? REQUEST_CAP : req;
    if (r <= WORD_BYTES) return 2 * WORD_BYTES;
    return WORD_BYTES + ((r + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
  endfunction

  task automatic pool_update(input in_item_t it, output out_item_t res);
    int unsigned new_stride;
    int unsigned cnt;
    logic [IDX_W-1:0] h;
    res = '0;
    case (it.cmd)
      CMD_INIT: begin
        new_stride = block_stride_of(req_cfg);
        if (pool_cfg < new_stride + WORD_BYTES) begin
          res.status = ST_TOO_SMALL;
          refusals++;
        end else begin
          cnt = (pool_cfg - WORD_BYTES) / new_stride;
          if (cnt > MAX_BLOCKS) cnt = MAX_BLOCKS;
          for (int i = 0; i < cnt; i++) begin
            link_mem[i] = (i + 1 < cnt) ? IDX_W'(i + 1) : '0;
          end
          foreach (used_mark[i]) used_mark[i] = 1'b0;
          held_blocks.delete();
          stride = new_stride;
          blk_count = cnt;
          free_cnt = cnt;
          head = '0;
          list_empty = (cnt == 0);
          pool_builds++;
        end
      end
      CMD_ALLOC: begin
        if (list_empty || free_cnt == 0) begin
          res.status = ST_NO_FREE;
          refusals++;
        end else begin
          h = head;
          res.granted_index = h;
          res.granted_offset = POOL_W'(2 * WORD_BYTES + h * stride);
          head = link_mem[h];
          used_mark[h] = 1'b1;
          held_blocks.push_back(h);
          free_cnt--;
          list_empty = (free_cnt == 0);
          grants++;
        end
      end
      CMD_FREE: begin
        if (it.block_index >= blk_count || !used_mark[it.block_index]) begin
          res.status = ST_BAD_INDEX;
          refusals++;
        end else begin
          link_mem[it.block_index] = list_empty ? '0 : head;
          head = it.block_index;
          used_mark[it.block_index] = 1'b0;
          for (int i = 0; i < held_blocks.size(); i++) begin
            if (held_blocks[i] == it.block_index) begin
              held_blocks.delete(i);
              break;
            end
          end
          free_cnt++;
          list_empty = 1'b0;
          returns++;
        end
      end
      default: ;
    endcase
    res.status = res.status;
    res.free_blocks = CNT_W'(free_cnt);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: holds each item until it is taken, then may idle before the next one.
  always @(negedge clk) begin : drive_items
    if (rst_n && (!in_valid || items_taken == items_sent)) begin
      if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= cmd_queue.pop_front();
        in_valid <= 1'b1;
        items_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: results are checked before the newly taken item is predicted.
  always @(posedge clk) begin : watch_ports
    out_item_t want;
    out_item_t got;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        got = out_data;
        if (pool_replies.size() == 0) begin
          $error("result with no command waiting: status %0d, free_blocks %0d",
                 got.status, got.free_blocks);
          fail_count++;
        end else begin
          want = pool_replies.pop_front();
          check_field("status", want.status, got.status);
          check_field("granted_index", want.granted_index, got.granted_index);
          check_field("granted_offset", want.granted_offset, got.granted_offset);
          check_field("free_blocks", want.free_blocks, got.free_blocks);
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        pool_update(in_data, want);
        pool_replies.push_back(want);
        items_taken++;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("fixed_block_pool_allocator_top test failed");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [1:0] c, input logic [IDX_W-1:0] idx);
    in_item_t it;
    it.cmd = c;
    it.block_index = idx;
    while (cmd_queue.size() >= 2) @(negedge clk);
    cmd_queue.push_back(it);
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || items_taken != items_sent || pool_replies.size() != 0)
      @(negedge clk);
  endtask

  task automatic reconfigure(input int unsigned pool, input int unsigned req);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_POOL_BYTES;
    cfg_wdata <= POOL_W'(pool);
    @(negedge clk);
    cfg_addr <= CFG_REQ_BYTES;
    cfg_wdata <= POOL_W'(req);
    @(negedge clk);
    cfg_we <= 1'b0;
    pool_cfg = pool;
    req_cfg = req;
    pool_settings++;
  endtask

  // Mostly allocate and free of held blocks; random frees, no-ops and rebuilds mixed in.
  task automatic queue_random(input int n);
    int unsigned pick;
    logic [1:0] c;
    logic [IDX_W-1:0] idx;
    repeat (n) begin
      pick = $urandom_range(99);
      c = CMD_ALLOC;
      idx = IDX_W'($urandom_range(MAX_BLOCKS - 1));
      if (pick < 3) c = CMD_INIT;
      else if (pick < 7) c = CMD_NONE;
      else if (pick < 17) c = CMD_FREE;
      else if (pick >= 55 && held_blocks.size() > 0) begin
        c = CMD_FREE;
        idx = held_blocks[$urandom_range(held_blocks.size() - 1)];
      end
      queue_cmd(c, idx);
    end
  endtask

  initial begin : run_phases
    int unsigned req;
    int unsigned pool;
    int unsigned blk_stride;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Nothing built yet: every command is refused or does nothing.
    queue_cmd(CMD_ALLOC, 10'd0);
    queue_cmd(CMD_FREE, 10'd5);
    queue_cmd(CMD_NONE, 10'd1023);
    queue_cmd(CMD_INIT, 10'd0);

    // Three blocks: drain the list, then reject a double free and an out-of-range one.
    reconfigure(8 + 16 * 3, 8);
    queue_cmd(CMD_INIT, 10'd0);
    repeat (4) queue_cmd(CMD_ALLOC, 10'd0);
    queue_cmd(CMD_FREE, 10'd1);
    queue_cmd(CMD_FREE, 10'd1);
    queue_cmd(CMD_FREE, 10'd3);
    queue_cmd(CMD_ALLOC, 10'd0);

    // A pool one byte too small is refused and the old pool stays in use.
    reconfigure(23, 8);
    queue_cmd(CMD_INIT, 10'd0);
    queue_cmd(CMD_FREE, 10'd0);

    // Largest pool with an empty request: the block count hits its cap.
    reconfigure(POOL_MAX, 0);
    queue_cmd(CMD_INIT, 10'd0);
    queue_cmd(CMD_ALLOC, 10'd0);
    queue_cmd(CMD_FREE, 10'd1023);
    queue_cmd(CMD_FREE, 10'd0);

    // A request above the cap is treated as the cap.
    reconfigure(POOL_MAX, 8191);
    queue_cmd(CMD_INIT, 10'd0);
    queue_cmd(CMD_ALLOC, 10'd0);
    queue_cmd(CMD_ALLOC, 10'd0);

    // An exact multiple of the word size still gets a header word.
    reconfigure(8 + 24 * 2, 16);
    queue_cmd(CMD_INIT, 10'd0);
    queue_cmd(CMD_ALLOC, 10'd0);
    queue_cmd(CMD_ALLOC, 10'd0);

    for (int p = 0; p < 40; p++) begin
      if (p == 14) begin
        send_idle_pct = 80;
        recv_idle_pct = 30;
      end else if (p == 28) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(7))
        0: req = $urandom_range(0, 16);
        1: req = REQUEST_CAP + $urandom_range(0, REQUEST_CAP - 1);
        2: req = WORD_BYTES * $urandom_range(1, REQUEST_CAP / WORD_BYTES);
        default: req = $urandom_range(1, REQUEST_CAP);
      endcase
      blk_stride = block_stride_of(req);
      case ($urandom_range(9))
        0: pool = $urandom_range(0, POOL_MAX);
        1: pool = $urandom_range(0, blk_stride + WORD_BYTES - 1);
        default: pool = WORD_BYTES + $urandom_range(1, 24) * blk_stride
                        + $urandom_range(0, blk_stride - 1);
      endcase
      if (pool > POOL_MAX) pool = POOL_MAX;
      reconfigure(pool, req);
      queue_cmd(CMD_INIT, IDX_W'($urandom_range(MAX_BLOCKS - 1)));
      queue_random(40);
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("Ran %0d commands over %0d pool settings: %0d pools built, %0d blocks granted,",
             items_taken, pool_settings, pool_builds, grants);
    $display("%0d blocks returned and %0d commands refused.", returns, refusals);
    if (fail_count == 0) begin
      $display("fixed_block_pool_allocator_top test passed");
    end else begin
      $display("fixed_block_pool_allocator_top test failed");
    end
    $finish;
  end

endmodule
